// ===== sv/trie_dictionary_build_lookup_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TRIE_DICTIONARY_BUILD_LOOKUP_MACROS_SVH
`define TRIE_DICTIONARY_BUILD_LOOKUP_MACROS_SVH

// same-cycle implication
`define TDBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/tdbl_pkg.sv =====
package tdbl_pkg;

  localparam logic [1:0] OP_BUILD = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  localparam logic [7:0] CHAR_NL = 8'd10;

  localparam int CQ_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BUILD,
    KIND_QUERY,
    KIND_CLEAR,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       is_nl;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_PWN,
    ST_B_CHR,
    ST_B_NEW,
    ST_B_LINK,
    ST_Q_CMP
  } state_t;

endpackage

// ===== sv/tdbl_front.sv =====
module tdbl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_byte_req,
  output logic             in_full,
  output logic             cmd_valid,
  output tdbl_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);

  tdbl_pkg::cmd_t q_r [tdbl_pkg::CQ_DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  tdbl_pkg::cmd_t cls;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    cls.ch    = in_byte_req;
    cls.is_nl = (in_byte_req == tdbl_pkg::CHAR_NL);
    case (in_op)
      tdbl_pkg::OP_BUILD: cls.kind = tdbl_pkg::KIND_BUILD;
      tdbl_pkg::OP_QUERY: cls.kind = tdbl_pkg::KIND_QUERY;
      tdbl_pkg::OP_CLEAR: cls.kind = tdbl_pkg::KIND_CLEAR;
      default:            cls.kind = tdbl_pkg::KIND_NOP;
    endcase
  end

  assign in_full   = (cnt_r == 2'(tdbl_pkg::CQ_DEPTH));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_push   = in_push && !in_full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== sv/tdbl_back.sv =====
module tdbl_back #(
  parameter int NODES    = 4096,
  parameter int MAX_WORD = 64,
  parameter int CW       = $clog2(NODES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  tdbl_pkg::cmd_t   cmd_in,
  output logic             cmd_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [1:0]       out_status,
  output logic             out_match_alive,
  output logic             out_found,
  output logic             out_word_end,
  output logic [CW-1:0]    out_nodes_used
);

  localparam int IW = $clog2(NODES);
  localparam int PW = $clog2(MAX_WORD);
  localparam int LW = $clog2(MAX_WORD + 1);

  logic [7:0]    char_mem [NODES];
  logic [IW:0]   sib_mem  [NODES];
  logic [IW-1:0] pwn_mem  [MAX_WORD];

  tdbl_pkg::state_t state_r, state_nxt;
  tdbl_pkg::cmd_t   cmd_r, cmd_nxt;
  tdbl_pkg::cmd_t   cur_cmd;
  logic [CW-1:0]    count_r, count_nxt;
  logic [LW-1:0]    prev_len_r, prev_len_nxt;
  logic [PW-1:0]    build_pos_r, build_pos_nxt;
  logic [CW-1:0]    qcur_r, qcur_nxt;
  logic             qfail_r, qfail_nxt;
  logic [CW-1:0]    walk_i_r, walk_nxt;
  logic             link_r, link_nxt;

  logic [7:0]       char_rd_r;
  logic [IW:0]      sib_rd_r;
  logic [IW-1:0]    pwn_rd_r;

  logic             res_valid_r, res_valid_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic             res_alive_r, res_alive_nxt;
  logic             res_found_r, res_found_nxt;
  logic             res_word_end_r, res_word_end_nxt;
  logic [CW-1:0]    res_nodes_r, res_nodes_nxt;

  logic             node_re;
  logic [IW-1:0]    node_raddr;
  logic             pwn_re;
  logic [PW-1:0]    pwn_raddr;
  logic             char_we;
  logic [IW-1:0]    char_waddr;
  logic [7:0]       char_wdata;
  logic             sib_we;
  logic [IW-1:0]    sib_waddr;
  logic [IW:0]      sib_wdata;
  logic             pwn_we;
  logic [PW-1:0]    pwn_waddr;
  logic [IW-1:0]    pwn_wdata;

  logic             fin;
  logic [1:0]       fin_status;
  logic             b_done;
  logic             q_done;
  logic             q_ok;
  logic [CW-1:0]    q_at;
  logic             do_clear;
  logic             sib_ok;
  logic [CW-1:0]    sib_idx;

  assign cur_cmd = (state_r == tdbl_pkg::ST_IDLE) ? cmd_in : cmd_r;
  assign sib_ok  = sib_rd_r[IW];
  assign sib_idx = CW'(sib_rd_r[IW-1:0]);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    prev_len_nxt  = prev_len_r;
    build_pos_nxt = build_pos_r;
    qcur_nxt      = qcur_r;
    qfail_nxt     = qfail_r;
    walk_nxt      = walk_i_r;
    link_nxt      = link_r;
    cmd_pop       = 1'b0;
    node_re       = 1'b0;
    node_raddr    = '0;
    pwn_re        = 1'b0;
    pwn_raddr     = '0;
    char_we       = 1'b0;
    char_waddr    = '0;
    char_wdata    = '0;
    sib_we        = 1'b0;
    sib_waddr     = '0;
    sib_wdata     = '0;
    pwn_we        = 1'b0;
    pwn_waddr     = '0;
    pwn_wdata     = '0;
    fin           = 1'b0;
    fin_status    = tdbl_pkg::STATUS_OK;
    b_done        = 1'b0;
    q_done        = 1'b0;
    q_ok          = 1'b0;
    q_at          = '0;
    do_clear      = 1'b0;

    case (state_r)
      tdbl_pkg::ST_IDLE: begin
        if (cmd_valid && !res_valid_r) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_in;
          case (cmd_in.kind)
            tdbl_pkg::KIND_BUILD: begin
              if (!cmd_in.is_nl && build_pos_r >= PW'(MAX_WORD - 1)) begin
                fin        = 1'b1;
                fin_status = tdbl_pkg::STATUS_LONG;
              end else if (LW'(build_pos_r) < prev_len_r) begin
                pwn_re    = 1'b1;
                pwn_raddr = build_pos_r;
                link_nxt  = 1'b1;
                state_nxt = tdbl_pkg::ST_B_PWN;
              end else begin
                link_nxt  = 1'b0;
                state_nxt = tdbl_pkg::ST_B_NEW;
              end
            end
            tdbl_pkg::KIND_QUERY: begin
              if (qfail_r || qcur_r >= count_r) begin
                q_done = 1'b1;
              end else begin
                node_re    = 1'b1;
                node_raddr = qcur_r[IW-1:0];
                walk_nxt   = qcur_r;
                state_nxt  = tdbl_pkg::ST_Q_CMP;
              end
            end
            tdbl_pkg::KIND_CLEAR: begin
              fin      = 1'b1;
              do_clear = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      tdbl_pkg::ST_B_PWN: begin
        node_re    = 1'b1;
        node_raddr = pwn_rd_r;
        state_nxt  = tdbl_pkg::ST_B_CHR;
      end
      tdbl_pkg::ST_B_CHR: begin
        if (char_rd_r == cmd_r.ch) begin
          b_done = 1'b1;
        end else begin
          state_nxt = tdbl_pkg::ST_B_NEW;
        end
      end
      tdbl_pkg::ST_B_NEW: begin
        if (count_r >= CW'(NODES)) begin
          b_done     = 1'b1;
          fin_status = tdbl_pkg::STATUS_FULL;
        end else begin
          char_we      = 1'b1;
          char_waddr   = count_r[IW-1:0];
          char_wdata   = cmd_r.ch;
          sib_we       = 1'b1;
          sib_waddr    = count_r[IW-1:0];
          sib_wdata    = '0;
          pwn_we       = 1'b1;
          pwn_waddr    = build_pos_r;
          pwn_wdata    = count_r[IW-1:0];
          count_nxt    = count_r + CW'(1);
          prev_len_nxt = LW'(build_pos_r) + LW'(1);
          if (link_r) begin
            state_nxt = tdbl_pkg::ST_B_LINK;
          end else begin
            b_done = 1'b1;
          end
        end
      end
      tdbl_pkg::ST_B_LINK: begin
        sib_we    = 1'b1;
        sib_waddr = pwn_rd_r;
        sib_wdata = {1'b1, IW'(count_r - CW'(1))};
        b_done    = 1'b1;
      end
      tdbl_pkg::ST_Q_CMP: begin
        if (char_rd_r == cmd_r.ch) begin
          q_done = 1'b1;
          q_ok   = 1'b1;
          q_at   = walk_i_r;
        end else if (!sib_ok || sib_idx <= walk_i_r || sib_idx >= count_r) begin
          q_done = 1'b1;
        end else begin
          node_re    = 1'b1;
          node_raddr = sib_idx[IW-1:0];
          walk_nxt   = sib_idx;
        end
      end
      default: begin
        state_nxt = tdbl_pkg::ST_IDLE;
      end
    endcase

    if (b_done) begin
      fin           = 1'b1;
      build_pos_nxt = cmd_r.is_nl ? '0 : build_pos_r + PW'(1);
    end

    if (q_done) begin
      fin = 1'b1;
      if (cur_cmd.is_nl) begin
        qcur_nxt  = '0;
        qfail_nxt = 1'b0;
      end else if (q_ok) begin
        qcur_nxt = q_at + CW'(1);
      end else begin
        qfail_nxt = 1'b1;
      end
    end

    if (do_clear) begin
      count_nxt     = '0;
      prev_len_nxt  = '0;
      build_pos_nxt = '0;
      qcur_nxt      = '0;
      qfail_nxt     = 1'b0;
    end

    res_valid_nxt    = res_valid_r;
    res_status_nxt   = res_status_r;
    res_alive_nxt    = res_alive_r;
    res_found_nxt    = res_found_r;
    res_word_end_nxt = res_word_end_r;
    res_nodes_nxt    = res_nodes_r;
    if (out_pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
    if (fin) begin
      state_nxt        = tdbl_pkg::ST_IDLE;
      res_valid_nxt    = 1'b1;
      res_status_nxt   = fin_status;
      res_found_nxt    = q_done && cur_cmd.is_nl && q_ok;
      res_word_end_nxt = cur_cmd.is_nl && (cur_cmd.kind == tdbl_pkg::KIND_BUILD ||
                                           cur_cmd.kind == tdbl_pkg::KIND_QUERY);
      res_alive_nxt    = (q_done && cur_cmd.is_nl) ? q_ok : !qfail_nxt;
      res_nodes_nxt    = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdbl_pkg::ST_IDLE;
      count_r     <= '0;
      prev_len_r  <= '0;
      build_pos_r <= '0;
      qcur_r      <= '0;
      qfail_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      prev_len_r  <= prev_len_nxt;
      build_pos_r <= build_pos_nxt;
      qcur_r      <= qcur_nxt;
      qfail_r     <= qfail_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r          <= cmd_nxt;
    walk_i_r       <= walk_nxt;
    link_r         <= link_nxt;
    res_status_r   <= res_status_nxt;
    res_alive_r    <= res_alive_nxt;
    res_found_r    <= res_found_nxt;
    res_word_end_r <= res_word_end_nxt;
    res_nodes_r    <= res_nodes_nxt;
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[char_waddr] <= char_wdata;
    end
    if (node_re) begin
      char_rd_r <= char_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sib_we) begin
      sib_mem[sib_waddr] <= sib_wdata;
    end
    if (node_re) begin
      sib_rd_r <= sib_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pwn_we) begin
      pwn_mem[pwn_waddr] <= pwn_wdata;
    end
    if (pwn_re) begin
      pwn_rd_r <= pwn_mem[pwn_raddr];
    end
  end

  assign out_empty       = !res_valid_r;
  assign out_status      = res_status_r;
  assign out_match_alive = res_alive_r;
  assign out_found       = res_found_r;
  assign out_word_end    = res_word_end_r;
  assign out_nodes_used  = res_nodes_r;

endmodule

// ===== sv/trie_dictionary_build_lookup.sv =====
// Trie dictionary: build bytes (op 0) of a sorted, newline-ended word list grow a
// first-child / next-sibling trie of up to NODES nodes; query bytes (op 1) walk it
// and a query newline reports found; op 2 empties the dictionary. Each accepted beat
// gives exactly one result beat, in order. Input beats enter a two-entry command
// queue, so pushes continue while the engine works. The engine takes a command once
// the single result slot is empty. A clear, unused op, over-long byte, query already
// failed or query cursor past the stored nodes ends in the idle state. A build byte
// on the previous word's path reads its path node (B_PWN), checks its byte (B_CHR);
// one past the end of that path adds a node (B_NEW); one that leaves the path runs
// B_PWN, B_CHR, B_NEW, B_LINK, since it adds a node and links it as a sibling; one
// on a full store is dropped. A query byte compares in Q_CMP, one node memory read
// per sibling link walked. A result appears in the cycle after the engine finishes.
module trie_dictionary_build_lookup #(
  parameter int NODES    = 4096,
  parameter int MAX_WORD = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [1:0]                 in_op,
  input  logic [7:0]                 in_byte_req,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic [1:0]                 out_status,
  output logic                       out_match_alive,
  output logic                       out_found,
  output logic                       out_word_end,
  output logic [$clog2(NODES+1)-1:0] out_nodes_used
);

  tdbl_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_pop;

  tdbl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_op       (in_op),
    .in_byte_req (in_byte_req),
    .in_full     (in_full),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  tdbl_back #(
    .NODES    (NODES),
    .MAX_WORD (MAX_WORD)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd_valid),
    .cmd_in          (cmd),
    .cmd_pop         (cmd_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_match_alive (out_match_alive),
    .out_found       (out_found),
    .out_word_end    (out_word_end),
    .out_nodes_used  (out_nodes_used)
  );

endmodule

// ===== sv/tdbl_checker.sv =====
`include "trie_dictionary_build_lookup_macros.svh"

module tdbl_checker #(
  parameter int NODES = 4096
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_empty,
  input logic                       out_pop,
  input logic [1:0]                 out_status,
  input logic                       out_match_alive,
  input logic                       out_found,
  input logic                       out_word_end,
  input logic [$clog2(NODES+1)-1:0] out_nodes_used
);

  localparam int CW = $clog2(NODES + 1);

  `TDBL_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_status) && $stable(out_found) && $stable(out_nodes_used), "result beat changed while stalled")
  `TDBL_ASSERT_NOW(a_found_ends, clk, rst_n, !out_empty && out_found, out_word_end && out_match_alive && out_status == tdbl_pkg::STATUS_OK, "found without a matching word end")
  `TDBL_ASSERT_NOW(a_full_count, clk, rst_n, !out_empty && out_status == tdbl_pkg::STATUS_FULL, out_nodes_used == CW'(NODES), "store full reported below capacity")
  `TDBL_ASSERT_NOW(a_count_range, clk, rst_n, !out_empty, out_nodes_used <= CW'(NODES) && out_status != 2'd3, "node count or status out of range")

endmodule

bind trie_dictionary_build_lookup tdbl_checker #(.NODES(NODES)) u_tdbl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_status      (out_status),
  .out_match_alive (out_match_alive),
  .out_found       (out_found),
  .out_word_end    (out_word_end),
  .out_nodes_used  (out_nodes_used)
);
